// ===== src/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int PermDepth = 256;
  localparam int PermAw    = 8;
  localparam logic [PermAw-1:0] PermLast = 8'hFF;

  // action codes on the input channel
  localparam logic ActKey  = 1'b0;
  localparam logic ActData = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_K0,
    ST_K1,
    ST_K2,
    ST_K3
  } rc4_state_t;

  // work request from the front end to the engine
  typedef struct packed {
    logic       sched;
    logic       cipher;
    logic [7:0] data;
    logic       last;
  } rc4_cmd_t;

  // finished result from the engine
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } rc4_res_t;

endpackage

// ===== src/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rc4_engine.sv =====
// ----------------------------------------------------------------------------
// rc4_engine
// Sequencer around the permutation RAM: key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_engine
  import rc4_pkg::*;
#(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  rc4_cmd_t                              cmd,
  input  logic [$clog2(KEY_MAX_BYTES+1)-1:0]    key_len,
  output logic [(KEY_MAX_BYTES > 1 ? $clog2(KEY_MAX_BYTES) : 1)-1:0] key_raddr,
  input  logic [7:0]                            key_rdata,
  input  logic                                  out_free,
  output logic                                  busy,
  output rc4_res_t                              res
);

  localparam int CW = $clog2(KEY_MAX_BYTES + 1);
  localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  rc4_state_t state_r, state_nxt;

  logic [PermAw-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [PermAw-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [7:0]        a_r, a_nxt, b_r, b_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              last_r, last_nxt;
  logic              fwd_r, fwd_nxt;
  logic [KW-1:0]     kidx_r, kidx_nxt;
  logic [CW-1:0]     len_r, len_nxt;
  logic [CW-1:0]     kinc;

  logic [PermDepth-1:0] pvalid_r;
  logic                 rd_valid_r;
  logic [PermAw-1:0]    rd_addr_r;

  logic              p_we, p_re, clr_valid;
  logic [PermAw-1:0] p_waddr, p_raddr;
  logic [7:0]        p_wdata, p_q, pdat, ks;

  rc4_ram #(.W(8), .DEPTH(PermDepth)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_q)
  );

  // entries not written since the last identity reset read as their index
  assign pdat      = rd_valid_r ? p_q : rd_addr_r;
  assign ks        = fwd_r ? a_r : pdat;
  assign kinc      = CW'(kidx_r) + CW'(1);
  assign key_raddr = kidx_r;
  assign busy      = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.sched) begin
          state_nxt = ST_K0;
        end else if (cmd.cipher) begin
          state_nxt = ST_D0;
        end
      end
      ST_D0: state_nxt = ST_D1;
      ST_D1: state_nxt = ST_D2;
      ST_D2: state_nxt = ST_D3;
      ST_D3: state_nxt = ST_D4;
      ST_D4: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_K0: state_nxt = ST_K1;
      ST_K1: state_nxt = ST_K2;
      ST_K2: state_nxt = ST_K3;
      ST_K3: begin
        state_nxt = (i_r == PermLast) ? ST_IDLE : ST_K0;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    fwd_nxt   = fwd_r;
    kidx_nxt  = kidx_r;
    len_nxt   = len_r;
    p_we      = 1'b0;
    p_waddr   = '0;
    p_wdata   = '0;
    p_re      = 1'b0;
    p_raddr   = '0;
    clr_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.sched) begin
          len_nxt   = key_len;
          i_nxt     = '0;
          j_nxt     = '0;
          kidx_nxt  = '0;
          clr_valid = 1'b1;
        end else if (cmd.cipher) begin
          data_nxt = cmd.data;
          last_nxt = cmd.last;
        end
      end
      ST_D0: begin
        x_nxt   = x_r + 8'd1;
        p_re    = 1'b1;
        p_raddr = x_r + 8'd1;
      end
      ST_D1: begin
        a_nxt   = pdat;
        y_nxt   = y_r + pdat;
        p_re    = 1'b1;
        p_raddr = y_r + pdat;
      end
      ST_D2: begin
        b_nxt   = pdat;
        p_we    = 1'b1;
        p_waddr = x_r;
        p_wdata = pdat;
      end
      ST_D3: begin
        p_we    = 1'b1;
        p_waddr = y_r;
        p_wdata = a_r;
        p_re    = 1'b1;
        p_raddr = a_r + b_r;
        // keystream index hits the entry written this cycle
        fwd_nxt = ((a_r + b_r) == y_r);
      end
      ST_D4: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.data  = data_r ^ ks;
          res.last  = last_r;
        end
      end
      ST_K0: begin
        p_re    = 1'b1;
        p_raddr = i_r;
      end
      ST_K1: begin
        a_nxt   = pdat;
        j_nxt   = j_r + pdat + key_rdata;
        p_re    = 1'b1;
        p_raddr = j_r + pdat + key_rdata;
      end
      ST_K2: begin
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = pdat;
      end
      ST_K3: begin
        p_we     = 1'b1;
        p_waddr  = j_r;
        p_wdata  = a_r;
        i_nxt    = i_r + 8'd1;
        kidx_nxt = (kinc == len_r) ? '0 : kinc[KW-1:0];
        if (i_r == PermLast) begin
          x_nxt = '0;
          y_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      x_r        <= '0;
      y_r        <= '0;
      pvalid_r   <= '0;
      rd_valid_r <= 1'b0;
      rd_addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      if (clr_valid) begin
        pvalid_r <= '0;
      end else if (p_we) begin
        pvalid_r[p_waddr] <= 1'b1;
      end
      if (p_re) begin
        rd_valid_r <= pvalid_r[p_raddr];
        rd_addr_r  <= p_raddr;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    fwd_r  <= fwd_nxt;
    kidx_r <= kidx_nxt;
    len_r  <= len_nxt;
  end

endmodule

// ===== src/rc4_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 cipher: key loading, key schedule and byte-wise keystream XOR.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per byte. in_action
//   low sends a key byte, stored in order; in_last_byte on a key byte starts
//   the key schedule over the bytes held (at most KEY_MAX_BYTES; extra bytes
//   are dropped). in_action high sends a data byte to encrypt or decrypt.
//   Output channel (out_valid/out_ready): one transaction per data byte,
//   out_byte = data XOR keystream, out_last echoes in_last_byte.
//   Sequencing: a key byte is absorbed in the accept cycle. The last key
//   byte starts a schedule of 256 swaps (four RAM accesses per swap:
//   read, read, write, write), during which in_ready is low. A data byte
//   runs through states D0 to D4 (read, read, write, then a write with the
//   keystream read on the permutation memory), then hands its result to
//   the output register; the next byte is accepted only once the engine is idle.
//   Stall: a result waits in the output register; the engine holds its last
//   step until the register frees, and in_ready stays low meanwhile.
//   Reset: permutation is identity (per-entry valid bits, no clearing pass),
//   indices and key count zero; data before any key uses identity.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core
  import rc4_pkg::*;
#(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int CW = $clog2(KEY_MAX_BYTES + 1);
  localparam int KW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

  logic          busy, accept, out_free;
  logic          key_full, key_we;
  logic [CW-1:0] key_cnt_r, key_cnt_nxt, cnt_after;
  logic [CW-1:0] key_len;
  logic [KW-1:0] key_raddr;
  logic [7:0]    key_rdata;
  rc4_cmd_t      cmd;
  rc4_res_t      res;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // key byte bookkeeping; count saturates at the store size
  assign key_full  = (key_cnt_r >= CW'(KEY_MAX_BYTES));
  assign key_we    = accept && (in_action == ActKey) && !key_full;
  assign cnt_after = key_full ? key_cnt_r : key_cnt_r + CW'(1);

  always_comb begin
    key_cnt_nxt = key_cnt_r;
    key_len     = cnt_after;
    cmd         = '0;
    cmd.data    = in_byte_in;
    cmd.last    = in_last_byte;
    if (accept) begin
      if (in_action == ActKey) begin
        key_cnt_nxt = cnt_after;
        // empty key: schedule skipped, old state kept
        if (in_last_byte && (cnt_after != '0)) begin
          cmd.sched   = 1'b1;
          key_cnt_nxt = '0;
        end
      end else begin
        cmd.cipher = 1'b1;
      end
    end
  end

  rc4_ram #(.W(8), .DEPTH(KEY_MAX_BYTES)) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_cnt_r[KW-1:0]),
    .wdata (in_byte_in),
    .re    (1'b1),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  rc4_engine #(.KEY_MAX_BYTES(KEY_MAX_BYTES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .key_len   (key_len),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .out_free  (out_free),
    .busy      (busy),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      key_cnt_r <= key_cnt_nxt;
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte_r <= res.data;
      out_last_r <= res.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
